// ===== rtl/core/ring_scope_segment_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Ring scope segment generator - assertion macros
// Implication checks, same cycle and next cycle, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RING_SCOPE_SEGMENT_GENERATOR_MACROS_SVH
`define RING_SCOPE_SEGMENT_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is asserted
`define RSSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RSSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RSSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define RSSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/rssg_pkg.sv =====
// ----------------------------------------------------------------------------
// rssg_pkg
// Shared types, register indexes and elaboration-time helpers.
// ----------------------------------------------------------------------------
package rssg_pkg;

	localparam int DIM_W   = 13;
	localparam int SIZE_W  = 8;
	localparam int COORD_W = 17;
	localparam int SEG_W   = 7;
	localparam int CIDX_W  = 3;
	localparam int IN_W    = 32;
	localparam int OUT_W   = 80;

	// register indexes on the write port
	localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_RING_SIZE      = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_CHANNEL_CHOICE = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_PLACEMENT      = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_SOURCE_MODE    = 3'd5;

	localparam logic [1:0] CH_FIRST      = 2'd0;
	localparam logic [1:0] CH_SECOND     = 2'd1;
	localparam logic [1:0] PLACE_QUARTER = 2'd0;
	localparam logic [1:0] PLACE_HALF    = 2'd2;

	// pi in Q2.30
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef enum logic [1:0] {
		MUL_SIDE   = 2'd0,
		MUL_RADIUS = 2'd1,
		MUL_COS    = 2'd2,
		MUL_SIN    = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     take;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     point_en;
		logic     commit;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic k_zero;
	} stat_t;

	typedef struct packed {
		logic                      done;
		logic                      visible;
		logic signed [COORD_W-1:0] ey;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] sx;
		logic [SEG_W-1:0]          idx;
	} seg_t;

	// Q1.15 rounding with clamp to [0, 1.0) from a Q2.30 value
	function automatic logic [15:0] round_q15(input longint v);
		longint t;
		t = v;
		if (t < 0) t = 0;
		if (t > (longint'(1) << 30)) t = longint'(1) << 30;
		t = (t + 16384) >>> 15;
		if (t > 32767) t = 32767;
		return 16'(t);
	endfunction

endpackage

// ===== rtl/core/rssg_datapath.sv =====
// ----------------------------------------------------------------------------
// rssg_datapath
// Config registers, magnitude, shared multiplier, point math, ring state.
// ----------------------------------------------------------------------------
`include "ring_scope_segment_generator_macros.svh"

module rssg_datapath #(
	parameter int SEGMENTS = 80
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rssg_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [rssg_pkg::DIM_W-1:0]   cfg_data,
	input  logic [rssg_pkg::IN_W-1:0]    s_tdata,
	input  rssg_pkg::cmd_t               cmd,
	output rssg_pkg::stat_t              status,
	output rssg_pkg::seg_t               seg_fwd,
	output rssg_pkg::seg_t               seg_mir
);
	import rssg_pkg::*;

	localparam int HALF = SEGMENTS / 2;
	localparam int KW   = $clog2(HALF + 1);
	localparam int IW   = $clog2(SEGMENTS + 2);
	localparam int RS_W = 2 * DIM_W + SIZE_W + 3;   // 37: side*size*scale
	localparam int MB_W = 16;
	localparam int PR_W = RS_W + MB_W;

	localparam logic signed [COORD_W+1:0] SAT_LO = -19'sd65536;
	localparam logic signed [COORD_W+1:0] SAT_HI = 19'sd65535;

	// cos/sin in Q1.15 from a folded angle phi (Q2.30), Taylor series at elaboration
	function automatic logic signed [15:0] trig_q15(input longint unsigned phi,
			input logic neg, input logic want_sin);
		longint unsigned p2;
		longint unsigned ts;
		longint unsigned tc;
		longint sv;
		longint cv;
		logic signed [15:0] r;
		sv  = 0;
		cv  = 0;
		p2  = (phi * phi) >> 30;
		ts  = phi;
		tc  = longint'(1) << 30;
		for (int i = 0; i < 8; i++) begin
			if (i[0]) begin
				sv = sv - longint'(ts);
				cv = cv - longint'(tc);
			end else begin
				sv = sv + longint'(ts);
				cv = cv + longint'(tc);
			end
			// next terms: sin over (2i+2)(2i+3), cos over (2i+1)(2i+2)
			case (i)
				0: begin
					ts = ((ts * p2) >> 30) / 64'd6;
					tc = ((tc * p2) >> 30) >> 1;
				end
				1: begin
					ts = ((ts * p2) >> 30) / 64'd20;
					tc = ((tc * p2) >> 30) / 64'd12;
				end
				2: begin
					ts = ((ts * p2) >> 30) / 64'd42;
					tc = ((tc * p2) >> 30) / 64'd30;
				end
				3: begin
					ts = ((ts * p2) >> 30) / 64'd72;
					tc = ((tc * p2) >> 30) / 64'd56;
				end
				4: begin
					ts = ((ts * p2) >> 30) / 64'd110;
					tc = ((tc * p2) >> 30) / 64'd90;
				end
				5: begin
					ts = ((ts * p2) >> 30) / 64'd156;
					tc = ((tc * p2) >> 30) / 64'd132;
				end
				6: begin
					ts = ((ts * p2) >> 30) / 64'd210;
					tc = ((tc * p2) >> 30) / 64'd182;
				end
				default: ;
			endcase
		end
		r = $signed(round_q15(want_sin ? sv : cv));
		if (!want_sin && neg) r = -r;
		return r;
	endfunction

	function automatic logic in_frame(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		return !x[COORD_W-1] && (x[COORD_W-2:0] < {3'b000, w}) &&
			!y[COORD_W-1] && (y[COORD_W-2:0] < {3'b000, h});
	endfunction

	function automatic logic signed [COORD_W-1:0] sat17(input logic signed [COORD_W+1:0] v);
		if (v < SAT_LO) return SAT_LO[COORD_W-1:0];
		if (v > SAT_HI) return SAT_HI[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [7:0] pick(input logic [1:0] ch, input logic [7:0] a,
			input logic [7:0] b);
		logic [7:0] r;
		case (ch)
			CH_FIRST:  r = a;
			CH_SECOND: r = b;
			default:   r = (a >> 1) + (b >> 1);
		endcase
		return r;
	endfunction

	// constant tables
	logic signed [15:0] cos_tab [0:HALF];
	logic signed [15:0] sin_tab [0:HALF];
	logic [15:0]        scale_tab [0:255];

	// angle 2*pi*g/SEGMENTS folded into the first quadrant
	for (genvar g = 0; g <= HALF; g++) begin : g_trig
		localparam longint unsigned N_RAW  = (2 * g > SEGMENTS) ? SEGMENTS : 2 * g;
		localparam bit              NEG    = (2 * N_RAW > SEGMENTS);
		localparam longint unsigned N_FOLD = NEG ? SEGMENTS - N_RAW : N_RAW;
		localparam longint unsigned PHI    = (PI_Q30 * N_FOLD) / SEGMENTS;
		assign cos_tab[g] = trig_q15(PHI, NEG, 1'b0);
		assign sin_tab[g] = trig_q15(PHI, NEG, 1'b1);
	end

	// Q0.16 gain 0.1 + 0.9*m/255
	for (genvar g = 0; g < 256; g++) begin : g_scale
		localparam int SCALE = 6553 + (g * 58982) / 255;
		assign scale_tab[g] = 16'(SCALE);
	end

	// config registers
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [SIZE_W-1:0] size_q;
	logic [1:0]        chan_q;
	logic [1:0]        place_q;
	logic              mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd480;
			size_q   <= 8'd16;
			chan_q   <= CH_FIRST;
			place_q  <= PLACE_QUARTER;
			mode_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:    width_q  <= cfg_data;
				CFG_FRAME_HEIGHT:   height_q <= cfg_data;
				CFG_RING_SIZE:      size_q   <= cfg_data[SIZE_W-1:0];
				CFG_CHANNEL_CHOICE: chan_q   <= cfg_data[1:0];
				CFG_PLACEMENT:      place_q  <= cfg_data[1:0];
				CFG_SOURCE_MODE:    mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item intake
	logic [7:0] pick_even;
	logic [7:0] pick_odd;
	logic [7:0] mag;
	logic [KW-1:0] k_eff;
	logic [DIM_W-1:0] side;

	assign pick_even = pick(chan_q, s_tdata[7:0], s_tdata[15:8]);
	assign pick_odd  = pick(chan_q, s_tdata[23:16], s_tdata[31:24]);
	assign mag       = mode_q ? ((pick_even >> 1) + (pick_odd >> 1)) : (pick_even ^ 8'h80);
	assign side      = (width_q < height_q) ? width_q : height_q;

	logic [KW-1:0]    count_q;
	logic [KW-1:0]    k_q;
	logic [7:0]       m_q;
	logic [DIM_W-1:0] side_q;

	assign k_eff = (count_q > KW'(HALF)) ? '0 : count_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			k_q    <= k_eff;
			m_q    <= mag;
			side_q <= side;
		end
	end

	// shared multiplier
	logic signed [15:0] cos_val;
	logic signed [15:0] sin_val;
	logic               cos_neg;
	logic [14:0]        cos_mag;
	logic [RS_W-1:0]    mul_a;
	logic [MB_W-1:0]    mul_b;
	logic [PR_W-1:0]    prod;

	logic [DIM_W+SIZE_W-1:0] pside_q;
	logic [15:0]             scale_q;
	logic [RS_W-1:0]         rs_q;
	logic signed [COORD_W:0] offx_q;
	logic signed [COORD_W:0] offy_q;

	assign cos_val = cos_tab[k_q];
	assign sin_val = sin_tab[k_q];
	assign cos_neg = cos_val[15];
	assign cos_mag = cos_neg ? 15'(-cos_val) : cos_val[14:0];

	always_comb begin
		case (cmd.mul_sel)
			MUL_SIDE: begin
				mul_a = RS_W'(side_q);
				mul_b = MB_W'(size_q);
			end
			MUL_RADIUS: begin
				mul_a = RS_W'(pside_q);
				mul_b = scale_q;
			end
			MUL_COS: begin
				mul_a = rs_q;
				mul_b = {1'b0, cos_mag};
			end
			default: begin
				mul_a = rs_q;
				mul_b = sin_val;
			end
		endcase
	end

	assign prod = PR_W'(mul_a) * PR_W'(mul_b);

	logic [COORD_W-1:0] prod_hi;
	assign prod_hi = prod[36 +: COORD_W];

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MUL_SIDE: begin
					pside_q <= prod[DIM_W+SIZE_W-1:0];
					scale_q <= scale_tab[m_q];
				end
				MUL_RADIUS: rs_q <= prod[RS_W-1:0];
				MUL_COS: offx_q <= cos_neg ? -$signed({1'b0, prod_hi}) : $signed({1'b0, prod_hi});
				default: offy_q <= $signed({1'b0, prod_hi});
			endcase
		end
	end

	// point placement
	logic [DIM_W-1:0] cx;
	logic [DIM_W-1:0] cy;
	logic signed [COORD_W+1:0] cx_s;
	logic signed [COORD_W+1:0] cy_s;

	always_comb begin
		case (place_q)
			PLACE_QUARTER: cx = width_q >> 2;
			PLACE_HALF:    cx = width_q >> 1;
			default:       cx = (width_q >> 1) + (width_q >> 2);
		endcase
	end
	assign cy   = height_q >> 1;
	assign cx_s = $signed({6'b0, cx});
	assign cy_s = $signed({6'b0, cy});

	logic signed [COORD_W-1:0] px_q;
	logic signed [COORD_W-1:0] fy_q;
	logic signed [COORD_W-1:0] my_q;

	always_ff @(posedge clk) begin
		if (cmd.point_en) begin
			px_q <= sat17(cx_s + (COORD_W+2)'(offx_q));
			fy_q <= sat17(cy_s - (COORD_W+2)'(offy_q));
			my_q <= sat17(cy_s + (COORD_W+2)'(offy_q));
		end
	end

	// ring state
	logic signed [COORD_W-1:0] fwd_x_q;
	logic signed [COORD_W-1:0] fwd_y_q;
	logic signed [COORD_W-1:0] mir_x_q;
	logic signed [COORD_W-1:0] mir_y_q;
	logic                      k_last;

	assign k_last = (k_q == KW'(HALF));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fwd_x_q <= '0;
			fwd_y_q <= '0;
			mir_x_q <= '0;
			mir_y_q <= '0;
		end else if (cmd.commit) begin
			count_q <= k_last ? '0 : k_q + 1'b1;
			fwd_x_q <= px_q;
			fwd_y_q <= fy_q;
			mir_x_q <= px_q;
			mir_y_q <= my_q;
		end
	end

	assign status.k_zero = (k_q == '0);

	logic [IW-1:0] mir_idx;
	assign mir_idx = IW'(SEGMENTS + 1) - IW'(k_q);

	always_comb begin
		seg_fwd.idx     = SEG_W'(k_q);
		seg_fwd.sx      = px_q;
		seg_fwd.sy      = fy_q;
		seg_fwd.ex      = fwd_x_q;
		seg_fwd.ey      = fwd_y_q;
		seg_fwd.visible = in_frame(px_q, fy_q, width_q, height_q) ||
			in_frame(fwd_x_q, fwd_y_q, width_q, height_q);
		seg_fwd.done    = 1'b0;

		seg_mir.idx     = SEG_W'(mir_idx);
		seg_mir.sx      = mir_x_q;
		seg_mir.sy      = mir_y_q;
		seg_mir.ex      = px_q;
		seg_mir.ey      = my_q;
		seg_mir.visible = in_frame(mir_x_q, mir_y_q, width_q, height_q) ||
			in_frame(px_q, my_q, width_q, height_q);
		seg_mir.done    = k_last;
	end

	`RSSG_ASSERT_IMPLY(a_count_range, clk, arst_n, cmd.take, k_eff <= KW'(HALF), "count beyond half ring")
	`RSSG_ASSERT_NEXT(a_count_wrap, clk, arst_n, cmd.commit && k_last, count_q == '0, "count did not wrap at frame end")
	`RSSG_ASSERT_NEXT(a_count_step, clk, arst_n, cmd.commit && !k_last, count_q != '0, "count stuck at zero after commit")

endmodule

// ===== rtl/core/rssg_ctrl.sv =====
// ----------------------------------------------------------------------------
// rssg_ctrl
// Sequencer: intake, four multiplier steps, point step, commit.
// ----------------------------------------------------------------------------
`include "ring_scope_segment_generator_macros.svh"

module rssg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  rssg_pkg::stat_t   status,
	input  logic              load_ok,
	output rssg_pkg::cmd_t    cmd
);
	import rssg_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_MUL_A  = 7'b0000010,
		ST_MUL_B  = 7'b0000100,
		ST_MUL_C  = 7'b0001000,
		ST_MUL_D  = 7'b0010000,
		ST_POINT  = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = MUL_SIDE;
		s_tready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
				if (s_tvalid) state_d = ST_MUL_A;
			end
			ST_MUL_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SIDE;
				state_d     = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RADIUS;
				state_d     = ST_MUL_C;
			end
			ST_MUL_C: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_COS;
				state_d     = ST_MUL_D;
			end
			ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SIN;
				state_d     = ST_POINT;
			end
			ST_POINT: begin
				cmd.point_en = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_FINISH: begin
				// item 0 only seeds the ring; others wait for room in the output stage
				cmd.commit = status.k_zero || load_ok;
				cmd.emit   = !status.k_zero && load_ok;
				if (cmd.commit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`RSSG_ASSERT_IMPLY(a_emit_room, clk, arst_n, cmd.emit, load_ok, "emit without room in output stage")
	`RSSG_ASSERT_NEXT(a_busy_after_take, clk, arst_n, cmd.take, !s_tready, "ready right after a request")
	`RSSG_ASSERT_NEXT(a_no_quick_commit, clk, arst_n, cmd.take, !cmd.commit, "commit right after a request")

endmodule

// ===== rtl/core/rssg_out_stage.sv =====
// ----------------------------------------------------------------------------
// rssg_out_stage
// Output register plus one pending slot for the second segment of a pair.
// ----------------------------------------------------------------------------
`include "ring_scope_segment_generator_macros.svh"

module rssg_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  rssg_pkg::seg_t              seg_fwd,
	input  rssg_pkg::seg_t              seg_mir,
	output logic                        load_ok,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rssg_pkg::OUT_W-1:0]  m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser
);
	import rssg_pkg::*;

	seg_t out_q;
	seg_t pend_q;
	logic o_valid_q;
	logic p_valid_q;
	logic pop;

	assign pop     = o_valid_q && m_tready;
	assign load_ok = !p_valid_q && (!o_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			p_valid_q <= 1'b0;
		end else if (load) begin
			o_valid_q <= 1'b1;
			p_valid_q <= 1'b1;
		end else if (pop) begin
			if (p_valid_q) begin
				p_valid_q <= 1'b0;
			end else begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= seg_fwd;
			pend_q <= seg_mir;
		end else if (pop && p_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {5'b00000, out_q.ey, out_q.ex, out_q.sy, out_q.sx, out_q.idx};
	assign m_tlast  = out_q.done;
	assign m_tuser  = out_q.visible;

	`RSSG_ASSERT_IMPLY(a_pend_has_out, clk, arst_n, p_valid_q, o_valid_q, "pending slot full with output empty")
	`RSSG_ASSERT_IMPLY(a_last_alone, clk, arst_n, o_valid_q && out_q.done, !p_valid_q, "segment queued behind frame end")
	`RSSG_ASSERT_NEXT(a_pend_moves, clk, arst_n, pop && p_valid_q, o_valid_q && !p_valid_q, "pending segment lost")

endmodule

// ===== rtl/core/ring_scope_segment_generator.sv =====
// ----------------------------------------------------------------------------
// ring_scope_segment_generator
// Places mirrored ring points from audio magnitudes and emits ring segments.
// ----------------------------------------------------------------------------
//  channel | role        | payload
//  s_*     | item in     | tdata: first_even, second_even, first_odd, second_odd
//  m_*     | segment out | tdata: seg_index, start_x, start_y, end_x, end_y;
//          |             | tuser: visible; tlast: frame_done
//  cfg_*   | reg write   | index per register list, data 13 bits
//
//  Each item goes through intake, four passes through the one shared
//  37x16 multiplier (side*size, *scale, *cos, *sin), point step, commit.
//  Items 1..SEGMENTS/2 emit two segments; the commit waits while the output
//  stage still holds an earlier pair. The next item is taken while the last
//  segment of a pair waits at the output. Reset is asynchronous and clears
//  the config to 640x480, size 16, the ring state and the position count.
// ----------------------------------------------------------------------------
module ring_scope_segment_generator #(
	parameter int SEGMENTS = 80
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rssg_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [rssg_pkg::DIM_W-1:0]   cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [7:0] first_even, [15:8] second_even, [23:16] first_odd, [31:24] second_odd
	input  logic [rssg_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [6:0] seg_index, [23:7] start_x, [40:24] start_y, [57:41] end_x,
	// [74:58] end_y, [79:75] zero
	output logic [rssg_pkg::OUT_W-1:0]   m_tdata,
	output logic                         m_tlast,
	// [0] visible
	output logic                         m_tuser
);
	import rssg_pkg::*;

	cmd_t  cmd;
	stat_t status;
	seg_t  seg_fwd;
	seg_t  seg_mir;
	logic  load_ok;

	rssg_datapath #(
		.SEGMENTS (SEGMENTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.seg_fwd   (seg_fwd),
		.seg_mir   (seg_mir)
	);

	rssg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.load_ok  (load_ok),
		.cmd      (cmd)
	);

	rssg_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.emit),
		.seg_fwd  (seg_fwd),
		.seg_mir  (seg_mir),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring scope segment generator testbench
// Streams audio positions through the block under a series of register
// settings, predicts every ring segment in step with the input handshakes and
// checks the segment stream field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;

	typedef longint unsigned u64_t;

	typedef struct {
		logic [6:0]         idx;
		logic signed [16:0] sx;
		logic signed [16:0] sy;
		logic signed [16:0] ex;
		logic signed [16:0] ey;
		logic               vis;
		logic               done;
	} ring_seg_t;

	localparam int SEGMENTS      = 80;
	localparam int HALF          = SEGMENTS / 2;
	localparam int PHASES        = 14;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 400;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [rssg_pkg::CIDX_W-1:0]         cfg_index = '0;
	logic [rssg_pkg::DIM_W-1:0]          cfg_data = '0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [rssg_pkg::IN_W-1:0]           s_tdata = '0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [rssg_pkg::OUT_W-1:0]          m_tdata;
	logic                                m_tlast;
	logic                                m_tuser;

	// register copies
	int unsigned cfg_w = 640, cfg_h = 480, cfg_size = 16;
	int unsigned cfg_ch = 0, cfg_place = 0, cfg_src = 0;

	// ring state: next position, last forward point, last mirrored point
	int unsigned ring_pos = 0;
	int          fwd_x = 0, fwd_y = 0, mir_x = 0, mir_y = 0;

	int          cos_q15[0:HALF];
	int          sin_q15[0:HALF];

	logic [31:0] sample_q[$];
	ring_seg_t   segs_due[$];
	int          errors = 0;
	int          idle_pct = 30;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	ring_scope_segment_generator #(.SEGMENTS(SEGMENTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	function automatic int to_q15(input longint v);
		if (v < 0) v = 0;
		if (v > (longint'(1) << 30)) v = longint'(1) << 30;
		v = (v + 16384) >>> 15;
		return (v > 32767) ? 32767 : int'(v);
	endfunction

	// cos/sin of 2*pi*k/SEGMENTS by an 8-term series in Q2.30
	function automatic void ring_angle(input int k, output int c, output int s);
		u64_t   n, phi, p2, ts, tc;
		longint sv, cv;
		bit     neg;
		int     i;
		n = u64_t'(2 * k);
		neg = 1'b0;
		sv = 0;
		cv = 0;
		if (n > SEGMENTS) n = SEGMENTS;
		if (2 * n > SEGMENTS) begin
			n = SEGMENTS - n;
			neg = 1'b1;
		end
		phi = (rssg_pkg::PI_Q30 * n) / u64_t'(SEGMENTS);
		p2 = (phi * phi) >> 30;
		ts = phi;
		tc = u64_t'(1) << 30;
		for (i = 0; i < 8; i++) begin
			if (i & 1) begin
				sv -= longint'(ts);
				cv -= longint'(tc);
			end else begin
				sv += longint'(ts);
				cv += longint'(tc);
			end
			ts = ((ts * p2) >> 30) / u64_t'((2 * i + 2) * (2 * i + 3));
			tc = ((tc * p2) >> 30) / u64_t'((2 * i + 1) * (2 * i + 2));
		end
		s = to_q15(sv);
		c = neg ? -to_q15(cv) : to_q15(cv);
	endfunction

	// radius product times trig, truncated toward zero
	function automatic longint trig_offset(input u64_t rs, input int t);
		u64_t mag, v;
		mag = (t < 0) ? u64_t'(-t) : u64_t'(t);
		v = (rs * mag) >> 36;
		return (t < 0) ? -longint'(v) : longint'(v);
	endfunction

	function automatic int clamp17(input longint v);
		if (v < -65536) return -65536;
		if (v > 65535) return 65535;
		return int'(v);
	endfunction

	function automatic int unsigned chan_byte(input logic [7:0] a, input logic [7:0] b);
		if (cfg_ch == rssg_pkg::CH_FIRST) return a;
		if (cfg_ch == rssg_pkg::CH_SECOND) return b;
		return a / 2 + b / 2;
	endfunction

	function automatic bit in_frame(input int x, input int y);
		return x >= 0 && x < int'(cfg_w) && y >= 0 && y < int'(cfg_h);
	endfunction

	function automatic ring_seg_t make_seg(input int unsigned q, input int sx, input int sy,
			input int ex, input int ey, input bit done);
		ring_seg_t seg;
		seg.idx  = 7'(q);
		seg.sx   = 17'(sx);
		seg.sy   = 17'(sy);
		seg.ex   = 17'(ex);
		seg.ey   = 17'(ey);
		seg.vis  = in_frame(sx, sy) || in_frame(ex, ey);
		seg.done = done;
		return seg;
	endfunction

	// place the two mirrored points of one position, queue the segments they close
	task automatic place_points(input logic [31:0] word);
		int unsigned k, mag, gain, side;
		u64_t        rs;
		longint      cx, cy, ox, oy;
		int          px, fy, my;
		k = ring_pos;
		if (k > HALF) k = 0;
		if (cfg_src != 0)
			mag = chan_byte(word[7:0], word[15:8]) / 2 + chan_byte(word[23:16], word[31:24]) / 2;
		else
			mag = chan_byte(word[7:0], word[15:8]) ^ 32'd128;
		gain = 6553 + (mag * 58982) / 255;
		side = (cfg_w < cfg_h) ? cfg_w : cfg_h;
		rs = u64_t'(side) * u64_t'(cfg_size) * u64_t'(gain);
		cy = cfg_h / 2;
		if (cfg_place == rssg_pkg::PLACE_HALF) cx = cfg_w / 2;
		else if (cfg_place == rssg_pkg::PLACE_QUARTER) cx = cfg_w / 4;
		else cx = cfg_w / 2 + cfg_w / 4;
		ox = trig_offset(rs, cos_q15[k]);
		oy = trig_offset(rs, sin_q15[k]);
		px = clamp17(cx + ox);
		fy = clamp17(cy - oy);
		my = clamp17(cy + oy);
		if (k != 0) begin
			segs_due.push_back(make_seg(k, px, fy, fwd_x, fwd_y, 1'b0));
			segs_due.push_back(make_seg(SEGMENTS + 1 - k, mir_x, mir_y, px, my, k == HALF));
		end
		fwd_x = px;
		fwd_y = fy;
		mir_x = px;
		mir_y = my;
		ring_pos = (k == HALF) ? 0 : k + 1;
	endtask

	task automatic field_cmp(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_segment();
		ring_seg_t want;
		if (segs_due.size() == 0) begin
			$display("%0t: segment with no request pending: expected none actual tdata=%h",
				$time, m_tdata);
			errors++;
		end else begin
			want = segs_due.pop_front();
			field_cmp("seg_index", want.idx, m_tdata[6:0]);
			field_cmp("start_x", want.sx, $signed(m_tdata[23:7]));
			field_cmp("start_y", want.sy, $signed(m_tdata[40:24]));
			field_cmp("end_x", want.ex, $signed(m_tdata[57:41]));
			field_cmp("end_y", want.ey, $signed(m_tdata[74:58]));
			field_cmp("tdata pad", 0, m_tdata[79:75]);
			field_cmp("visible", want.vis, m_tuser);
			field_cmp("frame_done", want.done, m_tlast);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) place_points(sample_q.pop_front());
			if (!s_tvalid || s_tready) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= sample_q[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, started on request from the stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// segment monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) check_segment();
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic write_reg(input logic [rssg_pkg::CIDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= rssg_pkg::DIM_W'(val);
	endtask

	task automatic load_regs(input int unsigned w, input int unsigned h, input int unsigned sz,
			input int unsigned ch, input int unsigned pl, input int unsigned src);
		write_reg(rssg_pkg::CFG_FRAME_WIDTH, w);
		write_reg(rssg_pkg::CFG_FRAME_HEIGHT, h);
		write_reg(rssg_pkg::CFG_RING_SIZE, sz);
		write_reg(rssg_pkg::CFG_CHANNEL_CHOICE, ch);
		write_reg(rssg_pkg::CFG_PLACEMENT, pl);
		write_reg(rssg_pkg::CFG_SOURCE_MODE, src);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_w = w;
		cfg_h = h;
		cfg_size = sz;
		cfg_ch = ch;
		cfg_place = pl;
		cfg_src = src;
	endtask

	// all requests taken and all segments back, then let a silent item finish
	task automatic settle();
		while (sample_q.size() != 0 || s_tvalid || segs_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic int unsigned rand_dim();
		return ($urandom_range(3) == 0) ? $urandom_range(1, 8191) : $urandom_range(8, 800);
	endfunction

	initial begin
		logic [31:0] corners[12];
		int          ph, i, n;
		for (i = 0; i <= HALF; i++) ring_angle(i, cos_q15[i], sin_q15[i]);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// byte extremes and bit patterns under the reset settings
		corners = '{32'h00000000, 32'hFFFFFFFF, 32'h80808080, 32'h7F7F7F7F,
			32'h55AA55AA, 32'hAA55AA55, 32'h0000FFFF, 32'hFFFF0000,
			32'h01010101, 32'hFEFEFEFE, 32'h80008000, 32'h00800080};
		foreach (corners[j]) sample_q.push_back(corners[j]);
		for (i = 0; i < 13; i++) sample_q.push_back($urandom);
		settle();

		for (ph = 1; ph <= PHASES; ph++) begin
			case (ph)
				1: load_regs(8191, 8191, 255, 0, 1, 0);   // coordinates saturate
				2: load_regs(0, 480, 16, 1, 2, 1);        // zero width
				3: load_regs(640, 0, 200, 2, 3, 0);       // zero height
				4: load_regs(1, 1, 0, 3, 0, 1);
				5: load_regs(4096, 4096, 255, 0, 0, 1);
				6: load_regs(64, 48, 32, 1, 3, 0);
				default: load_regs(rand_dim(), rand_dim(), $urandom_range(255),
					$urandom_range(3), $urandom_range(3), $urandom_range(1));
			endcase
			idle_pct = (ph == 7) ? 0 : 30;
			n = $urandom_range(55, 75);
			for (i = 0; i < n; i++)
				sample_q.push_back({rand_byte(), rand_byte(), rand_byte(), rand_byte()});
			if (ph == 3 || ph == 10) hold_req++;
			settle();
		end

		if (errors == 0) begin
			$display("ring_scope_segment_generator regression: pass");
		end else begin
			$display("ring_scope_segment_generator regression: fail");
		end
		$finish;
	end

	initial begin
		#6ms;
		$display("ring_scope_segment_generator regression: fail");
		$finish;
	end

endmodule
